// ===== sv/bfba_pkg.sv =====
package bfba_pkg;

    // Fixed field widths of the request and result ports
    localparam int unsigned REQ_W  = 7;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned STS_W  = 2;

    typedef enum logic [STS_W-1:0] {
        STS_DONE    = 2'd0,
        STS_NOFIT   = 2'd1,
        STS_BADADDR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_END,
        S_A_CUT,
        S_A_SPLIT,
        S_F_CHK,
        S_F_HD,
        S_F_NX,
        S_F_WR,
        S_F_ZERO,
        S_RESP
    } t_state;

    // Sequencer to datapath
    typedef struct packed {
        t_state state;
        logic   busy;
        logic   done;
    } t_seq_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic start;
        logic kind;
        logic alu_ge;    // adder result at or past heap end
        logic found;
        logic arg_bad;
        logic e_pos;     // entry read is an allocated header
        logic spare_nz;
        logic merge;
    } t_dp_flags;

endpackage

// ===== sv/bfba_alu.sv =====
module bfba_alu #(
    parameter int unsigned W = 9
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_inv_b,
    input  logic         i_cin,
    output logic [W:0]   o_sum
);

    logic [W-1:0] b_eff;

    assign b_eff = i_inv_b ? ~i_b : i_b;
    // top bit is carry out: with i_inv_b and i_cin set it flags a >= b
    assign o_sum = {1'b0, i_a} + {1'b0, b_eff} + (W+1)'(i_cin);

endmodule

// ===== sv/bfba_mem.sv =====
module bfba_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned WIDTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/bfba_seq.sv =====
module bfba_seq
    import bfba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_flags i_flags,
    output t_seq_ctl  o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_flags.alu_ge) n_state = S_IDLE;
            S_IDLE: begin
                if (i_flags.start) begin
                    n_state = i_flags.kind ? S_F_CHK : S_A_RD;
                end
            end
            S_A_RD: begin
                if (i_flags.alu_ge) begin
                    n_state = i_flags.found ? S_A_END : S_RESP;
                end else begin
                    n_state = S_A_EV;
                end
            end
            S_A_EV:    n_state = S_A_RD;
            S_A_END:   n_state = S_A_CUT;
            S_A_CUT: begin
                n_state = (i_flags.spare_nz && !i_flags.alu_ge) ? S_A_SPLIT : S_RESP;
            end
            S_A_SPLIT: n_state = S_RESP;
            S_F_CHK:   n_state = i_flags.arg_bad ? S_RESP : S_F_HD;
            S_F_HD:    n_state = i_flags.e_pos ? S_F_NX : S_RESP;
            S_F_NX:    n_state = S_F_WR;
            S_F_WR:    n_state = i_flags.merge ? S_F_ZERO : S_RESP;
            S_F_ZERO:  n_state = S_RESP;
            S_RESP:    n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl.state = r_state;
        o_ctl.busy  = (r_state != S_IDLE);
        o_ctl.done  = (r_state == S_RESP);
    end

endmodule

// ===== sv/best_fit_block_allocator_unit.sv =====
// Best-fit block allocator over a heap of HEAP_WORDS words.
// The heap is an implicit list of blocks; a table holds one signed size per
// word (positive = allocated, negative = free, zero = not a header).
// Request channel: start with i_kind / i_request_size / i_free_addr is taken
// on a clock edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Result channel: o_done is high for exactly one cycle with o_status and
// o_address valid; the receiver cannot stall it.
// Allocate: walks block headers through the size table, each header visited
// with a table read, then a fit test in the shared adder; then writes the
// header, splits off the remainder and responds (or responds at once when
// nothing fits). The walk is bound by the table's single read port and the
// one adder.
// Free: range check, header read, next-header read, rewrite, merge clear,
// respond.
// One request at a time; the next request can start the cycle after o_done.
// Reset (i_rst_n low, synchronous) starts a clearing pass that writes one
// free block over the whole heap; busy is high throughout it.
module best_fit_block_allocator_unit
    import bfba_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [REQ_W-1:0]  i_request_size,
    input  logic [ADDR_W-1:0] i_free_addr,
    output logic              o_done,
    output logic [STS_W-1:0]  o_status,
    output logic [ADDR_W-1:0] o_address
);

    // IW: table index, EW: signed table entry, AW: adder/position width
    localparam int unsigned IW = $clog2(HEAP_WORDS);
    localparam int unsigned EW = IW + 2;
    localparam int unsigned AW = (EW > 9) ? EW : 9;
    localparam logic [AW-1:0] HEAP_A   = AW'(HEAP_WORDS);
    localparam logic [EW-1:0] HEAP_E   = EW'(HEAP_WORDS);
    localparam logic [EW-1:0] NEG_HEAP = ~HEAP_E + EW'(1);

    t_seq_ctl  ctl;
    t_dp_flags flags;

    // shared adder
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic          alu_inv;
    logic          alu_cin;
    logic [AW:0]   alu_sum;
    logic [AW-1:0] alu_res;
    logic          alu_ge;

    // size table port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    logic [AW-1:0] rd_sext;
    logic          rd_neg;
    logic          rd_pos;

    // walk and request state
    logic [AW-1:0]    r_pos;       // walk position, also clear-pass counter
    logic [AW-1:0]    r_step;      // next advance (len-1 with carry for free blocks)
    logic             r_cin;
    logic             r_found;
    logic [AW-1:0]    r_best;      // spare words of best candidate
    logic [IW-1:0]    r_at;        // header of best candidate
    logic [AW-1:0]    r_arg;       // need (allocate) or header index (free)
    logic [REQ_W-1:0] r_req;
    logic [AW-1:0]    r_nx;
    logic             r_nx_ok;
    logic [EW-1:0]    r_len;
    logic [EW-1:0]    r_wval;
    logic             r_merge;
    t_status          r_status;
    logic [ADDR_W-1:0] r_addr;

    logic fit;
    logic better;

    assign alu_res = alu_sum[AW-1:0];
    assign alu_ge  = (alu_res >= HEAP_A);
    assign rd_sext = AW'($signed(mem_rdata));
    assign rd_neg  = mem_rdata[EW-1];
    assign rd_pos  = !mem_rdata[EW-1] && (mem_rdata != '0);

    // in S_A_EV the adder forms (len-1) - request_size; carry out means it fits
    assign fit    = rd_neg && alu_sum[AW];
    assign better = !r_found || (alu_res < r_best);

    bfba_alu #(
        .W (AW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_inv_b (alu_inv),
        .i_cin   (alu_cin),
        .o_sum   (alu_sum)
    );

    bfba_mem #(
        .DEPTH (HEAP_WORDS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        flags.start    = start;
        flags.kind     = i_kind;
        flags.alu_ge   = alu_ge;
        flags.found    = r_found;
        flags.arg_bad  = (r_arg >= HEAP_A);
        flags.e_pos    = rd_pos;
        flags.spare_nz = (r_best != '0);
        flags.merge    = r_merge;
    end

    bfba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    // Operand routing and table access per sequencer step
    always_comb begin
        alu_a     = '0;
        alu_b     = '0;
        alu_inv   = 1'b0;
        alu_cin   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (ctl.state)
            S_CLEAR: begin
                alu_a     = r_pos;
                alu_cin   = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_pos[IW-1:0];
                mem_wdata = (r_pos == '0) ? NEG_HEAP : '0;
            end
            S_IDLE: begin
                // need = size + 1, or header = addr - 1
                alu_a   = i_kind ? AW'(i_free_addr) : AW'(i_request_size);
                alu_b   = i_kind ? AW'(1) : '0;
                alu_inv = i_kind;
                alu_cin = 1'b1;
            end
            S_A_RD: begin
                alu_a     = r_pos;
                alu_b     = r_step;
                alu_cin   = r_cin;
                mem_re    = !alu_ge;
                mem_raddr = alu_res[IW-1:0];
            end
            S_A_EV: begin
                alu_a   = ~rd_sext;
                alu_b   = AW'(r_req);
                alu_inv = 1'b1;
                alu_cin = 1'b1;
            end
            S_A_END: begin
                alu_a     = AW'(r_at);
                alu_cin   = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_at;
                mem_wdata = r_arg[EW-1:0];
            end
            S_A_CUT: begin
                alu_a = AW'(r_at);
                alu_b = r_arg;
            end
            S_A_SPLIT: begin
                alu_b     = r_best;
                alu_inv   = 1'b1;
                alu_cin   = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_nx[IW-1:0];
                mem_wdata = alu_res[EW-1:0];
            end
            S_F_CHK: begin
                mem_re    = !flags.arg_bad;
                mem_raddr = r_arg[IW-1:0];
            end
            S_F_HD: begin
                alu_a     = r_arg;
                alu_b     = rd_sext;
                mem_re    = rd_pos && !alu_ge;
                mem_raddr = alu_res[IW-1:0];
            end
            S_F_NX: begin
                // merged size is next - len, plain free is 0 - len
                alu_a   = (r_nx_ok && rd_neg) ? rd_sext : '0;
                alu_b   = AW'($signed(r_len));
                alu_inv = 1'b1;
                alu_cin = 1'b1;
            end
            S_F_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_arg[IW-1:0];
                mem_wdata = r_wval;
            end
            S_F_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_nx[IW-1:0];
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Walk position doubles as the clear-pass counter, so it is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            unique case (ctl.state)
                S_CLEAR: r_pos <= alu_res;
                S_IDLE:  r_pos <= '0;
                S_A_RD:  r_pos <= alu_res;
                default: r_pos <= r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (ctl.state)
            S_IDLE: begin
                if (start) begin
                    r_arg    <= alu_res;
                    r_req    <= i_request_size;
                    r_step   <= '0;
                    r_cin    <= 1'b0;
                    r_found  <= 1'b0;
                    r_status <= STS_DONE;
                    r_addr   <= '0;
                end
            end
            S_A_RD: begin
                if (alu_ge && !r_found) begin
                    r_status <= STS_NOFIT;
                end
            end
            S_A_EV: begin
                if (fit && better) begin
                    r_found <= 1'b1;
                    r_best  <= alu_res;
                    r_at    <= r_pos[IW-1:0];
                end
                // free: advance len = (len-1)+1; allocated: len; non-header: 1
                if (rd_neg) begin
                    r_step <= ~rd_sext;
                    r_cin  <= 1'b1;
                end else begin
                    r_step <= rd_sext;
                    r_cin  <= !rd_pos;
                end
            end
            S_A_END: begin
                r_addr <= alu_res[ADDR_W-1:0];
            end
            S_A_CUT: begin
                r_nx <= alu_res;
            end
            S_F_CHK: begin
                if (flags.arg_bad) begin
                    r_status <= STS_BADADDR;
                end
            end
            S_F_HD: begin
                r_len   <= mem_rdata;
                r_nx    <= alu_res;
                r_nx_ok <= !alu_ge;
                if (!rd_pos) begin
                    r_status <= STS_BADADDR;
                end
            end
            S_F_NX: begin
                r_wval  <= alu_res[EW-1:0];
                r_merge <= r_nx_ok && rd_neg;
            end
            default: begin
            end
        endcase
    end

    assign busy      = ctl.busy;
    assign o_done    = ctl.done;
    assign o_status  = r_status;
    assign o_address = r_addr;

endmodule

// ===== test/best_fit_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps

module best_fit_block_allocator_unit_test
    import bfba_pkg::*;
;

    localparam int unsigned HEAP_WORDS  = 128;
    localparam int          DIR_N       = 22;
    localparam int          RAND_N      = 1500;
    localparam int          CALM_FROM   = 1300;            // no idling past this item
    localparam int          TAIL_CYCLES = 2 * HEAP_WORDS + 10;
    // Far longer than the slowest request, the clearing pass after reset or
    // the longest sender gap.
    localparam int          STALL_LIMIT = 4000;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_kind;

    // One expected reply
    typedef struct {
        t_status          st;
        logic [ADDR_W-1:0] granted;
        int               seq;
    } t_reply;

    // One row of the directed table; typed = expected reply given in the row
    typedef struct {
        t_kind             kind;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_status           st;
        logic [ADDR_W-1:0] granted;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [REQ_W-1:0]  i_request_size;
    logic [ADDR_W-1:0] i_free_addr;
    logic              o_done;
    logic [STS_W-1:0]  o_status;
    logic [ADDR_W-1:0] o_address;

    // Shadow of the size table: >0 allocated, <0 free, 0 not a header
    int                heap_len [HEAP_WORDS];
    t_reply            pending_replies [$];
    logic [ADDR_W-1:0] held_blocks [$];       // payload addresses now allocated
    logic [ADDR_W-1:0] last_released;
    int                mismatch_count;
    int                quiet_cycles;
    int                request_seq;
    t_stim_row         stim_table [DIR_N];

    best_fit_block_allocator_unit #(
        .HEAP_WORDS(HEAP_WORDS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_request_size(i_request_size),
        .i_free_addr   (i_free_addr),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_address     (o_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int seq,
                                   input int got, input int want);
        $display("mismatch on reply %0d, %s: got %0d, want %0d", seq, what, got, want);
        mismatch_count++;
    endtask

    // Applies one request to the shadow heap and works out its reply.
    function automatic void predict_heap_reply(input t_kind kind,
                                               input logic [REQ_W-1:0] size,
                                               input logic [ADDR_W-1:0] addr,
                                               output t_status st,
                                               output logic [ADDR_W-1:0] granted);
        int pos;
        int len;
        int need;
        int spare;
        int best_spare;
        int at;
        int hd;
        int nx;
        bit found;
        st         = STS_DONE;
        granted    = '0;
        found      = 1'b0;
        best_spare = 0;
        at         = 0;
        if (kind == REQ_ALLOC) begin
            need = int'(size) + 1;
            pos  = 0;
            // walk the headers, keep the tightest free block, lowest address on a tie
            while (pos < HEAP_WORDS) begin
                len = (heap_len[pos] < 0) ? -heap_len[pos] : heap_len[pos];
                if (heap_len[pos] < 0 && len >= need) begin
                    spare = len - need;
                    if (!found || spare < best_spare) begin
                        found      = 1'b1;
                        best_spare = spare;
                        at         = pos;
                    end
                end
                pos += (len == 0) ? 1 : len;
            end
            if (found) begin
                len          = -heap_len[at];
                heap_len[at] = need;
                if (len != need && at + need < HEAP_WORDS)
                    heap_len[at + need] = -(len - need);
                granted = ADDR_W'(at + 1);
            end else begin
                st = STS_NOFIT;
            end
        end else begin
            if (addr == 0 || int'(addr) - 1 >= HEAP_WORDS) begin
                st = STS_BADADDR;
            end else begin
                hd = int'(addr) - 1;
                if (heap_len[hd] > 0) begin
                    len          = heap_len[hd];
                    nx           = hd + len;
                    heap_len[hd] = -len;
                    // forward merge only; a block at the heap end has no next block
                    if (nx < HEAP_WORDS && heap_len[nx] < 0) begin
                        heap_len[hd] = -(len - heap_len[nx]);
                        heap_len[nx] = 0;
                    end
                end else begin
                    st = STS_BADADDR;
                end
            end
        end
    endfunction

    // Drives one request from a falling edge, waits for it to be taken,
    // records the expected reply and returns on the next falling edge.
    task automatic issue_request(input t_kind kind, input logic [REQ_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr, input int gap,
                                 input bit typed, input t_status want_st,
                                 input logic [ADDR_W-1:0] want_granted);
        t_reply r;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          = 1'b1;
        i_kind         = kind;
        i_request_size = size;
        i_free_addr    = addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_heap_reply(kind, size, addr, r.st, r.granted);
        if (typed) begin
            r.st      = want_st;
            r.granted = want_granted;
        end
        r.seq = request_seq++;
        pending_replies.push_back(r);
        // keep the list of live blocks in step with the shadow heap
        if (r.st == STS_DONE && kind == REQ_ALLOC) begin
            held_blocks.push_back(r.granted);
        end else if (r.st == STS_DONE && kind == REQ_FREE) begin
            last_released = addr;
            foreach (held_blocks[k]) begin
                if (held_blocks[k] == addr) begin
                    held_blocks.delete(k);
                    break;
                end
            end
        end
        @(negedge i_clk);
    endtask

    // Sender holds off until every reply is in.
    task automatic drain_replies();
        start = 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
    endtask

    // Reply checker and activity counter for the watchdog
    always @(posedge i_clk) begin
        t_reply w;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_done) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("reply with no request open", -1, o_status, 0);
                end else begin
                    w = pending_replies.pop_front();
                    if (o_status !== w.st)
                        report_mismatch("status", w.seq, o_status, w.st);
                    if (o_address !== w.granted)
                        report_mismatch("address", w.seq, o_address, w.granted);
                end
            end
            if (o_done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: too long with nothing taken or shown
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_kind             kind;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        int                pick;
        int                gap;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = REQ_ALLOC;
        i_request_size = '0;
        i_free_addr    = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        request_seq    = 0;
        last_released  = '0;
        foreach (heap_len[k]) heap_len[k] = 0;
        heap_len[0] = -HEAP_WORDS;

        // Walks from reset; the first rows have replies plain from the spec.
        stim_table = '{
            // whole heap taken at once, no split
            '{REQ_ALLOC, 7'd127, 8'd0,   1'b1, STS_DONE,    8'd1},
            // full heap: even a header-only block does not fit
            '{REQ_ALLOC, 7'd0,   8'd0,   1'b1, STS_NOFIT,   8'd0},
            '{REQ_FREE,  7'd0,   8'd0,   1'b1, STS_BADADDR, 8'd0},  // address zero
            '{REQ_FREE,  7'd0,   8'd255, 1'b1, STS_BADADDR, 8'd0},  // far past heap
            '{REQ_FREE,  7'd0,   8'd129, 1'b1, STS_BADADDR, 8'd0},  // just past heap
            '{REQ_FREE,  7'd0,   8'd2,   1'b1, STS_BADADDR, 8'd0},  // not a header
            '{REQ_FREE,  7'd0,   8'd1,   1'b1, STS_DONE,    8'd0},  // block at heap end
            '{REQ_FREE,  7'd0,   8'd1,   1'b1, STS_BADADDR, 8'd0},  // already free
            // zero-size request, free_addr ignored
            '{REQ_ALLOC, 7'd0,   8'd255, 1'b1, STS_DONE,    8'd1},
            '{REQ_ALLOC, 7'd10,  8'd0,   1'b0, STS_DONE,    8'd0},
            '{REQ_ALLOC, 7'd5,   8'd0,   1'b0, STS_DONE,    8'd0},
            '{REQ_FREE,  7'd0,   8'd2,   1'b0, STS_DONE,    8'd0},  // next block in use
            '{REQ_ALLOC, 7'd3,   8'd0,   1'b0, STS_DONE,    8'd0},  // tighter of two
            '{REQ_FREE,  7'd0,   8'd13,  1'b0, STS_DONE,    8'd0},  // merges forward
            '{REQ_ALLOC, 7'd115, 8'd0,   1'b0, STS_DONE,    8'd0},  // exact fit
            '{REQ_ALLOC, 7'd0,   8'd0,   1'b0, STS_DONE,    8'd0},
            '{REQ_FREE,  7'd0,   8'd13,  1'b0, STS_DONE,    8'd0},  // ends at heap end
            '{REQ_FREE,  7'd127, 8'd1,   1'b0, STS_DONE,    8'd0},  // size ignored
            '{REQ_FREE,  7'd0,   8'd2,   1'b0, STS_DONE,    8'd0},
            '{REQ_FREE,  7'd0,   8'd6,   1'b0, STS_DONE,    8'd0},
            '{REQ_ALLOC, 7'd127, 8'd0,   1'b0, STS_DONE,    8'd0},  // fragmented
            '{REQ_FREE,  7'd0,   8'd128, 1'b0, STS_DONE,    8'd0}   // last word
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part; the first request waits out the clearing pass
        foreach (stim_table[n]) begin
            gap = ($urandom_range(2) == 0) ? $urandom_range(1, 13) : 0;
            issue_request(stim_table[n].kind, stim_table[n].size, stim_table[n].addr, gap,
                          stim_table[n].typed, stim_table[n].st, stim_table[n].granted);
        end
        drain_replies();

        // random part: mostly allocate / free of live blocks, some junk frees
        for (int n = 0; n < RAND_N; n++) begin
            size = REQ_W'($urandom);
            addr = ADDR_W'($urandom);
            pick = $urandom_range(99);
            if (held_blocks.size() > 12) pick += 20;   // keep the heap from choking
            if (pick < 50 || held_blocks.size() == 0 && pick < 90) begin
                kind = REQ_ALLOC;
                case ($urandom_range(19))
                    0:       size = REQ_W'($urandom_range(41, 127));
                    1, 2, 3: size = REQ_W'($urandom_range(8, 40));
                    default: size = REQ_W'($urandom_range(0, 7));
                endcase
            end else if (pick < 90) begin
                kind = REQ_FREE;
                addr = held_blocks[$urandom_range(held_blocks.size() - 1)];
            end else begin
                kind = REQ_FREE;
                // double free or an arbitrary address
                if ($urandom_range(1) == 0) addr = last_released;
            end
            // idle bursts, with whole stretches left clean and a calm tail
            if (n >= CALM_FROM || (n % 200) >= 150 || $urandom_range(3) != 0)
                gap = 0;
            else
                gap = $urandom_range(1, 13);
            if (n % 400 == 399) drain_replies();
            issue_request(kind, size, addr, gap, 1'b0, STS_DONE, '0);
        end

        start = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
